### src/llae_pkg.sv
// Shared types and constants for the life-like automaton engine.
`default_nettype none

package llae_pkg;

    localparam int CELLS_W    = 64;
    localparam int ROW_IDX_W  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GENERATIONS = 3'd0,
        CFG_GRID_WIDTH  = 3'd1,
        CFG_GRID_HEIGHT = 3'd2,
        CFG_BIRTH_COUNT = 3'd3,
        CFG_SURVIVE_MIN = 3'd4,
        CFG_SURVIVE_MAX = 3'd5
    } cfg_index_t;

    localparam logic [3:0] GENERATIONS_RST = 4'd2;
    localparam logic [6:0] GRID_WIDTH_RST  = 7'd64;
    localparam logic [6:0] GRID_HEIGHT_RST = 7'd64;
    localparam logic [3:0] BIRTH_COUNT_RST = 4'd3;
    localparam logic [3:0] SURVIVE_MIN_RST = 4'd1;
    localparam logic [3:0] SURVIVE_MAX_RST = 4'd5;

    typedef struct packed {
        logic [CELLS_W-1:0] row_cells;
        logic               last_row;
    } row_item_t;

    typedef struct packed {
        logic [CELLS_W-1:0]   out_cells;
        logic [ROW_IDX_W-1:0] out_row;
        logic                 out_last;
    } res_item_t;

endpackage

`default_nettype wire

### src/life_like_automaton_engine_unit.sv
// Life-like cellular automaton engine: row load, generation sweeps, row emit.
`default_nettype none

// Loads a binary grid one row per beat on the row channel (bit k is column k),
// then, on the beat flagged last_row, runs the configured number of generations
// of a life-like rule (birth on exactly birth_count neighbors, survival on
// survive_min..survive_max) and emits every row on the result channel, the final
// one flagged out_last. Cells outside grid_width x grid_height are dead; rows not
// loaded in a short frame read as dead. The grid lives in two row-wide banks of
// synchronous RAM used ping-pong: each generation streams the current bank
// through a three-row window, one row read per cycle, and writes the new rows
// into the other bank. Each emitted row goes through a read, a capture and a
// hand-off through the output register, and waits out any result stall. Rows
// are accepted only during the load phase, and the load counter restarts at
// row 0 after the last result beat. The banks need no clearing pass: a fill
// count marks which rows of the current bank hold data from this frame.
// Configuration may be written at any time the block is idle; cfg_ready is
// always high.
module life_like_automaton_engine_unit #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // row channel
    input  wire logic                            row_valid,
    output logic                                 row_stall,
    input  wire llae_pkg::row_item_t             row_data,
    // result channel
    output logic                                 res_valid,
    input  wire logic                            res_stall,
    output llae_pkg::res_item_t                  res_data,
    // configuration
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [llae_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [llae_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Rows actually stored; taller grids are capped here.
    localparam int ROWS = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    // Counters reach ROWS + 1 (flush step of a sweep).
    localparam int CW   = $clog2(ROWS + 2);
    localparam int OUT_CELLS_W = llae_pkg::CELLS_W;
    localparam int OUT_ROW_W   = llae_pkg::ROW_IDX_W;
    localparam logic [6:0] MAX_W7 = 7'(MAX_WIDTH);
    localparam logic [6:0] ROWS7  = 7'(ROWS);

    typedef enum logic [2:0] {
        S_LOAD,
        S_GEN,
        S_EMIT_RD,
        S_EMIT_CAP,
        S_EMIT_HOLD
    } state_t;

    // ---------------- configuration registers ----------------
    logic [3:0] generations_reg;
    logic [6:0] grid_width_reg;
    logic [6:0] grid_height_reg;
    logic [3:0] birth_count_reg;
    logic [3:0] survive_min_reg;
    logic [3:0] survive_max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            generations_reg <= llae_pkg::GENERATIONS_RST;
            grid_width_reg  <= llae_pkg::GRID_WIDTH_RST;
            grid_height_reg <= llae_pkg::GRID_HEIGHT_RST;
            birth_count_reg <= llae_pkg::BIRTH_COUNT_RST;
            survive_min_reg <= llae_pkg::SURVIVE_MIN_RST;
            survive_max_reg <= llae_pkg::SURVIVE_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                llae_pkg::CFG_GENERATIONS: generations_reg <= cfg_data[3:0];
                llae_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                llae_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                llae_pkg::CFG_BIRTH_COUNT: birth_count_reg <= cfg_data[3:0];
                llae_pkg::CFG_SURVIVE_MIN: survive_min_reg <= cfg_data[3:0];
                llae_pkg::CFG_SURVIVE_MAX: survive_max_reg <= cfg_data[3:0];
                default: ;  // indexes past the list are dropped
            endcase
        end
    end

    // ---------------- effective geometry ----------------
    logic [6:0]           eff_w;
    logic [6:0]           eff_h7;
    logic [CW-1:0]        eff_h;
    logic [MAX_WIDTH-1:0] width_mask;

    always_comb
    begin
        if (grid_width_reg == 7'd0)
            eff_w = 7'd1;
        else if (grid_width_reg > MAX_W7)
            eff_w = MAX_W7;
        else
            eff_w = grid_width_reg;

        if (grid_height_reg == 7'd0)
            eff_h7 = 7'd1;
        else if (grid_height_reg > ROWS7)
            eff_h7 = ROWS7;
        else
            eff_h7 = grid_height_reg;
        eff_h = CW'(eff_h7);

        for (int c = 0; c < MAX_WIDTH; c++)
            width_mask[c] = (7'(c) < eff_w);
    end

    // One row of the next generation from its three-row window.
    // Out-of-grid bits are already zero in the window rows.
    function automatic logic [MAX_WIDTH-1:0] next_row(
        input logic [MAX_WIDTH-1:0] above,
        input logic [MAX_WIDTH-1:0] here,
        input logic [MAX_WIDTH-1:0] below,
        input logic [MAX_WIDTH-1:0] mask,
        input logic [3:0]           birth,
        input logic [3:0]           smin,
        input logic [3:0]           smax
    );
        logic [MAX_WIDTH+1:0] ae;
        logic [MAX_WIDTH+1:0] he;
        logic [MAX_WIDTH+1:0] be;
        logic [3:0]           n;
        logic [MAX_WIDTH-1:0] res;
        ae = {1'b0, above, 1'b0};
        he = {1'b0, here, 1'b0};
        be = {1'b0, below, 1'b0};
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            n = {3'd0, ae[c]} + {3'd0, ae[c+1]} + {3'd0, ae[c+2]}
              + {3'd0, he[c]} + {3'd0, he[c+2]}
              + {3'd0, be[c]} + {3'd0, be[c+1]} + {3'd0, be[c+2]};
            if (he[c+1])
                res[c] = (n >= smin) && (n <= smax);
            else
                res[c] = (n == birth);
        end
        return res & mask;
    endfunction

    // ---------------- control state ----------------
    state_t        state_reg;
    logic          bank_reg;         // bank holding the current grid
    logic [CW-1:0] load_cnt_reg;     // rows loaded in this frame
    logic [CW-1:0] filled_reg;       // rows of the current bank holding frame data
    logic [CW-1:0] rd_cnt_reg;       // sweep / emit row pointer
    logic [3:0]    gen_cnt_reg;
    logic          pipe_valid_reg;   // a sweep read returns this cycle
    logic [CW-1:0] pipe_row_reg;
    logic          pipe_zero_reg;    // returning row reads as dead
    logic          res_valid_reg;

    logic [MAX_WIDTH-1:0]  win_above_reg;
    logic [MAX_WIDTH-1:0]  win_here_reg;
    llae_pkg::res_item_t   res_data_reg;

    // ---------------- banks ----------------
    logic [MAX_WIDTH-1:0] bank0_mem [ROWS];
    logic [MAX_WIDTH-1:0] bank1_mem [ROWS];
    logic [MAX_WIDTH-1:0] rd0_reg;
    logic [MAX_WIDTH-1:0] rd1_reg;

    logic                 row_acc;
    logic                 load_we;
    logic                 gen_we;
    logic                 we0;
    logic                 we1;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [MAX_WIDTH-1:0] wr_data;
    logic [MAX_WIDTH-1:0] rd_data;
    logic [MAX_WIDTH-1:0] below_row;
    logic [MAX_WIDTH-1:0] gen_row;
    logic [CW-1:0]        gen_row_idx;
    logic                 sweep_issue;
    logic                 sweep_done;
    logic                 last_gen;
    logic                 res_acc;

    assign row_stall = (state_reg != S_LOAD);
    assign row_acc   = row_valid && !row_stall;
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;
    assign res_acc   = res_valid_reg && !res_stall;

    always_comb
    begin
        rd_addr     = rd_cnt_reg[AW-1:0];
        rd_data     = bank_reg ? rd1_reg : rd0_reg;
        below_row   = pipe_zero_reg ? '0 : rd_data;
        gen_row     = next_row(win_above_reg, win_here_reg, below_row, width_mask,
                               birth_count_reg, survive_min_reg, survive_max_reg);
        gen_row_idx = pipe_row_reg - CW'(1);

        load_we = row_acc && (load_cnt_reg < eff_h);
        gen_we  = (state_reg == S_GEN) && pipe_valid_reg && (pipe_row_reg != '0);

        // loads go to the current bank, sweep results to the other one
        we0 = (load_we && !bank_reg) || (gen_we && bank_reg);
        we1 = (load_we && bank_reg) || (gen_we && !bank_reg);
        if (load_we)
        begin
            wr_addr = load_cnt_reg[AW-1:0];
            wr_data = row_data.row_cells[MAX_WIDTH-1:0] & width_mask;
        end
        else
        begin
            wr_addr = gen_row_idx[AW-1:0];
            wr_data = gen_row;
        end

        // the step at index H is the flush that closes out the bottom row
        sweep_issue = (rd_cnt_reg <= eff_h);
        sweep_done  = pipe_valid_reg && (pipe_row_reg == eff_h);
        last_gen    = ({1'b0, gen_cnt_reg} + 5'd1) == {1'b0, generations_reg};
    end

    always_ff @(posedge clk)
    begin
        if (we0)
            bank0_mem[wr_addr] <= wr_data;
        rd0_reg <= bank0_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
            bank1_mem[wr_addr] <= wr_data;
        rd1_reg <= bank1_mem[rd_addr];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            bank_reg       <= 1'b0;
            load_cnt_reg   <= '0;
            filled_reg     <= '0;
            rd_cnt_reg     <= '0;
            gen_cnt_reg    <= '0;
            pipe_valid_reg <= 1'b0;
            pipe_row_reg   <= '0;
            pipe_zero_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (row_acc)
                    begin
                        if (load_we)
                            load_cnt_reg <= load_cnt_reg + CW'(1);
                        if (row_data.last_row)
                        begin
                            filled_reg     <= load_we ? load_cnt_reg + CW'(1) : load_cnt_reg;
                            rd_cnt_reg     <= '0;
                            gen_cnt_reg    <= '0;
                            pipe_valid_reg <= 1'b0;
                            state_reg      <= (generations_reg == 4'd0) ? S_EMIT_RD : S_GEN;
                        end
                    end
                end

                S_GEN:
                begin
                    if (sweep_issue)
                    begin
                        pipe_valid_reg <= 1'b1;
                        pipe_row_reg   <= rd_cnt_reg;
                        pipe_zero_reg  <= (rd_cnt_reg >= filled_reg);
                        rd_cnt_reg     <= rd_cnt_reg + CW'(1);
                    end
                    else
                        pipe_valid_reg <= 1'b0;

                    if (sweep_done)
                    begin
                        bank_reg   <= !bank_reg;
                        filled_reg <= eff_h;
                        rd_cnt_reg <= '0;
                        if (last_gen)
                            state_reg <= S_EMIT_RD;
                        else
                            gen_cnt_reg <= gen_cnt_reg + 4'd1;
                    end
                end

                S_EMIT_RD:
                begin
                    pipe_zero_reg <= (rd_cnt_reg >= filled_reg);
                    state_reg     <= S_EMIT_CAP;
                end

                S_EMIT_CAP:
                begin
                    res_valid_reg <= 1'b1;
                    state_reg     <= S_EMIT_HOLD;
                end

                S_EMIT_HOLD:
                begin
                    if (res_acc)
                    begin
                        res_valid_reg <= 1'b0;
                        if (res_data_reg.out_last)
                        begin
                            load_cnt_reg <= '0;
                            state_reg    <= S_LOAD;
                        end
                        else
                        begin
                            rd_cnt_reg <= rd_cnt_reg + CW'(1);
                            state_reg  <= S_EMIT_RD;
                        end
                    end
                end

                default: state_reg <= S_LOAD;
            endcase
        end
    end

    // Window and output payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_GEN && pipe_valid_reg)
        begin
            win_above_reg <= (pipe_row_reg == '0) ? '0 : win_here_reg;
            win_here_reg  <= below_row;
        end
        if (state_reg == S_EMIT_CAP)
        begin
            res_data_reg.out_cells <= OUT_CELLS_W'(below_row & width_mask);
            res_data_reg.out_row   <= OUT_ROW_W'(rd_cnt_reg);
            res_data_reg.out_last  <= (rd_cnt_reg + CW'(1)) == eff_h;
        end
    end

    // ---------------- assertions ----------------
    a_no_load_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> row_stall)
        else $error("result beat pending while rows are accepted");

    a_reload_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && res_data.out_last) |=> !row_stall)
        else $error("load phase did not resume after the final result beat");

    a_sweep_only_in_gen: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid_reg |-> (state_reg == S_GEN))
        else $error("sweep read returned outside a generation");

    a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (7'(res_data.out_row) < 7'(eff_h)))
        else $error("emitted row index beyond grid height");

endmodule

`default_nettype wire
